// ----- src/pkfd_pkg.sv -----
`timescale 1ns / 1ps

package pkfd_pkg;

    // Table geometry and payload widths
    localparam int TABLE_ENTRIES = 64;
    localparam int PRICE_BITS    = 48;
    localparam int KEY_BITS      = 64;
    localparam int TICK_BITS     = 32;
    localparam int LIMIT_BITS    = 8;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int PROD_W        = PRICE_BITS + LIMIT_BITS;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd128;

    // Verdict codes
    localparam logic [2:0] V_UPDATED  = 3'd0;
    localparam logic [2:0] V_NEW      = 3'd1;
    localparam logic [2:0] V_FULL     = 3'd2;
    localparam logic [2:0] V_NONPOS   = 3'd3;
    localparam logic [2:0] V_DEVIATES = 3'd4;

    typedef struct packed {
        logic [KEY_BITS-1:0]          symbol_key;
        logic signed [PRICE_BITS-1:0] price;
    } t_in;

    typedef struct packed {
        logic                 accepted;
        logic [2:0]           verdict;
        logic [TICK_BITS-1:0] valid_ticks;
    } t_out;

    // Search token that walks down the cell chain
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic [IDX_W-1:0]      hit_idx;
        logic [PRICE_BITS-1:0] last;
        logic [TICK_BITS-1:0]  ticks;
    } t_tok;

    // Entry write broadcast to all cells
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      idx;
        logic [KEY_BITS-1:0]   key;
        logic [PRICE_BITS-1:0] price;
        logic [TICK_BITS-1:0]  ticks;
    } t_wr;

endpackage

// ----- src/per_key_price_deviation_filter_unit.sv -----
`timescale 1ns / 1ps

// Per-key price deviation filter. Each request carries a symbol key and a signed
// price with 16 fractional bits and yields one result: accepted flag, verdict and
// the entry's tick count. The table is a chain of TABLE_ENTRIES cells; a search
// token walks one cell per clock. A request passes through the walk, the
// registering of the difference and the limit product, one evaluate state that
// only hands over to the decision, and the decide state for the compare and the
// entry write. One request is in flight at a time; the next one can be taken in
// the cycle after the result is registered. A new request is taken while the
// previous result still waits in the output register; its decision then waits
// until that register frees. The deviation limit register (1/256 units of the
// last price, reset 128) must be written only while idle; the block itself does
// not enforce this.
module per_key_price_deviation_filter_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  pkfd_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output pkfd_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_we,
    input  logic [pkfd_pkg::LIMIT_BITS-1:0] i_cfg_data
);

    localparam int N       = pkfd_pkg::TABLE_ENTRIES;
    localparam int PBITS   = pkfd_pkg::PRICE_BITS;
    localparam int PROD_W  = pkfd_pkg::PROD_W;
    localparam int TBITS   = pkfd_pkg::TICK_BITS;
    localparam int CNT_W   = pkfd_pkg::CNT_W;
    localparam int IDX_W   = pkfd_pkg::IDX_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_EVAL   = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic                            r_inject;
    logic [pkfd_pkg::KEY_BITS-1:0]   r_key;
    logic signed [PBITS-1:0]         r_price;
    logic [pkfd_pkg::LIMIT_BITS-1:0] r_limit;
    logic [CNT_W-1:0]                r_used;
    logic                            r_found;
    logic [IDX_W-1:0]                r_hit_idx;
    logic [TBITS-1:0]                r_ticks;
    logic [PBITS-1:0]                r_diff;
    logic [PROD_W-1:0]               r_lim_prod;
    logic                            r_out_valid;
    pkfd_pkg::t_out                  r_out;
    pkfd_pkg::t_out                  n_out;
    pkfd_pkg::t_wr                   w_wr;
    pkfd_pkg::t_tok                  w_tok [0:N];
    logic                            w_in_acc;
    logic                            w_out_free;
    logic                            w_pos;
    logic                            w_too_far;
    logic [PBITS-1:0]                w_p;
    logic [TBITS-1:0]                w_next_ticks;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Inject the search token into the head of the chain
    always_comb begin
        w_tok[0]         = '0;
        w_tok[0].valid   = r_inject;
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            pkfd_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cell_idx (IDX_W'(g)),
                .i_used     (r_used),
                .i_key      (r_key),
                .i_tok      (w_tok[g]),
                .i_wr       (w_wr),
                .o_tok      (w_tok[g+1])
            );
        end
    endgenerate

    // Sequence one request through search, evaluate and decide
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_in_acc) n_state = S_SEARCH;
            S_SEARCH: if (w_tok[N].valid) n_state = S_EVAL;
            S_EVAL:   n_state = S_DECIDE;
            S_DECIDE: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Decide the verdict and the entry write
    assign w_p          = r_price;
    assign w_pos        = !r_price[PBITS-1] && (r_price != '0);
    assign w_too_far    = {r_diff, 8'b0} > r_lim_prod;
    assign w_next_ticks = (r_ticks == '1) ? r_ticks : r_ticks + TBITS'(1);

    always_comb begin
        n_out    = '0;
        w_wr     = '0;
        w_wr.key   = r_key;
        w_wr.price = w_p;
        if (!w_pos) begin
            n_out.verdict = pkfd_pkg::V_NONPOS;
        end else if (!r_found) begin
            n_out.accepted = 1'b1;
            if (r_used < CNT_W'(N)) begin
                n_out.verdict     = pkfd_pkg::V_NEW;
                n_out.valid_ticks = TBITS'(1);
                w_wr.en           = 1'b1;
                w_wr.idx          = r_used[IDX_W-1:0];
                w_wr.ticks        = TBITS'(1);
            end else begin
                n_out.verdict = pkfd_pkg::V_FULL;
            end
        end else if (w_too_far) begin
            n_out.verdict     = pkfd_pkg::V_DEVIATES;
            n_out.valid_ticks = r_ticks;
        end else begin
            n_out.accepted    = 1'b1;
            n_out.verdict     = pkfd_pkg::V_UPDATED;
            n_out.valid_ticks = w_next_ticks;
            w_wr.en           = 1'b1;
            w_wr.idx          = r_hit_idx;
            w_wr.ticks        = w_next_ticks;
        end
        if (!(r_state == S_DECIDE && w_out_free)) begin
            w_wr.en = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= 1'b0;
            r_used      <= '0;
            r_limit     <= pkfd_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= w_in_acc;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (w_wr.en && !r_found) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (r_state == S_DECIDE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the request, then the search result, difference and limit product, then the result
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_key   <= i_in_data.symbol_key;
            r_price <= i_in_data.price;
        end
        if (r_state == S_SEARCH && w_tok[N].valid) begin
            r_found    <= w_tok[N].found;
            r_hit_idx  <= w_tok[N].hit_idx;
            r_ticks    <= w_tok[N].ticks;
            r_diff     <= (w_p >= w_tok[N].last) ? w_p - w_tok[N].last
                                                 : w_tok[N].last - w_p;
            r_lim_prod <= PROD_W'(w_tok[N].last) * PROD_W'(r_limit);
        end
        if (r_state == S_DECIDE && w_out_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(N))
        else $error("fill count beyond table size");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_used != $past(r_used)) |-> r_used == $past(r_used) + CNT_W'(1))
        else $error("fill count moved by more than one");

    a_tail_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[N].valid |-> r_state == S_SEARCH)
        else $error("search token left the chain outside a search");

    a_result_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(r_state == S_DECIDE))
        else $error("result appeared without a decision");

    a_accept_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.accepted |->
            (r_out.verdict == pkfd_pkg::V_UPDATED) || (r_out.verdict == pkfd_pkg::V_NEW)
            || (r_out.verdict == pkfd_pkg::V_FULL))
        else $error("accepted result with a reject verdict");
`endif

endmodule

// ----- src/pkfd_cell.sv -----
`timescale 1ns / 1ps

module pkfd_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pkfd_pkg::IDX_W-1:0]  i_cell_idx,
    input  logic [pkfd_pkg::CNT_W-1:0]  i_used,
    input  logic [pkfd_pkg::KEY_BITS-1:0] i_key,
    input  pkfd_pkg::t_tok              i_tok,
    input  pkfd_pkg::t_wr               i_wr,
    output pkfd_pkg::t_tok              o_tok
);

    logic [pkfd_pkg::KEY_BITS-1:0]   r_key;
    logic [pkfd_pkg::PRICE_BITS-1:0] r_price;
    logic [pkfd_pkg::TICK_BITS-1:0]  r_ticks;
    pkfd_pkg::t_tok                  r_tok;
    pkfd_pkg::t_tok                  n_tok;
    logic                            w_occupied;
    logic                            w_match;

    // Entry is live when it lies below the fill count
    assign w_occupied = {1'b0, i_cell_idx} < i_used;
    assign w_match    = i_tok.valid && !i_tok.found && w_occupied && (r_key == i_key);

    // Pick up this entry on a hit, otherwise pass the token on
    always_comb begin
        n_tok = i_tok;
        if (w_match) begin
            n_tok.found   = 1'b1;
            n_tok.hit_idx = i_cell_idx;
            n_tok.last    = r_price;
            n_tok.ticks   = r_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found   <= n_tok.found;
        r_tok.hit_idx <= n_tok.hit_idx;
        r_tok.last    <= n_tok.last;
        r_tok.ticks   <= n_tok.ticks;
    end

    // Store the entry when the write is addressed here
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_cell_idx)) begin
            r_key   <= i_wr.key;
            r_price <= i_wr.price;
            r_ticks <= i_wr.ticks;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- sim/per_key_price_deviation_filter_unit_test.sv -----
`timescale 1ns / 1ps

module per_key_price_deviation_filter_unit_test;

    localparam int TABLE_ENTRIES = pkfd_pkg::TABLE_ENTRIES;
    localparam int PRICE_BITS    = pkfd_pkg::PRICE_BITS;
    localparam int KEY_BITS      = pkfd_pkg::KEY_BITS;
    localparam int TICK_BITS     = pkfd_pkg::TICK_BITS;
    localparam int LIMIT_BITS    = pkfd_pkg::LIMIT_BITS;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int TAIL_CYCLES    = 100;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int POOL_KEYS      = 90;
    localparam int BATCH_ITEMS    = 50;
    localparam int BATCHES        = 19;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = pkfd_pkg::LIMIT_RESET;
    localparam logic [PRICE_BITS-1:0] PRICE_MAX  = {1'b0, {(PRICE_BITS-1){1'b1}}};
    localparam logic [PRICE_BITS-1:0] PRICE_MIN  = {1'b1, {(PRICE_BITS-1){1'b0}}};
    localparam logic [PRICE_BITS-1:0] PRICE_HALF = {2'b01, {(PRICE_BITS-2){1'b0}}};
    localparam logic [KEY_BITS-1:0]   KEY_ZERO   = '0;
    localparam logic [KEY_BITS-1:0]   KEY_ONES   = '1;
    localparam logic [KEY_BITS-1:0]   KEY_EURUSD = 64'h4555_5255_5344_0000;
    localparam logic [KEY_BITS-1:0]   KEY_BTC    = 64'h0000_0000_0042_5443;

    typedef enum logic [1:0] {
        IDLE_SEND_LIGHT,
        IDLE_SEND_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    pkfd_pkg::t_in  in_data = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    pkfd_pkg::t_out out_data;
    logic           cfg_we = 1'b0;
    logic [LIMIT_BITS-1:0] cfg_data = '0;

    // Predictor copy of the price book and the limit register
    logic [KEY_BITS-1:0]   book_key   [TABLE_ENTRIES];
    logic [PRICE_BITS-1:0] book_last  [TABLE_ENTRIES];
    logic [TICK_BITS-1:0]  book_ticks [TABLE_ENTRIES];
    int unsigned           book_used = 0;
    logic [LIMIT_BITS-1:0] limit_copy = LIMIT_RESET;

    pkfd_pkg::t_in  pending_requests[$];
    pkfd_pkg::t_out expected_verdicts[$];
    t_idle_mode idle_mode = IDLE_SEND_LIGHT;
    int         holdoff_asks = 0;
    int         holdoff_seen = 0;
    int         holdoff_left = 0;
    int         mismatches = 0;
    int         requests_sent = 0;
    int         verdict_seen [8];
    int         cycle_count = 0;

    per_key_price_deviation_filter_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Screen one price update against the book and advance the book
    function automatic pkfd_pkg::t_out screen_request(pkfd_pkg::t_in req);
        pkfd_pkg::t_out        res;
        logic [PRICE_BITS-1:0] px;
        logic [63:0]           gap;
        logic [63:0]           allowance;
        int                    hit;
        res = '0;
        px  = req.price;
        hit = -1;
        if (px == '0 || px[PRICE_BITS-1]) begin
            res.verdict = pkfd_pkg::V_NONPOS;
            return res;
        end
        for (int i = 0; i < book_used; i++) begin
            if (hit < 0 && book_key[i] == req.symbol_key) hit = i;
        end
        if (hit < 0) begin
            res.accepted = 1'b1;
            if (book_used < TABLE_ENTRIES) begin
                book_key[book_used]   = req.symbol_key;
                book_last[book_used]  = px;
                book_ticks[book_used] = 1;
                book_used++;
                res.verdict     = pkfd_pkg::V_NEW;
                res.valid_ticks = 1;
            end else begin
                res.verdict = pkfd_pkg::V_FULL;
            end
            return res;
        end
        gap = (px >= book_last[hit]) ? 64'(px - book_last[hit]) : 64'(book_last[hit] - px);
        allowance = 64'(limit_copy) * 64'(book_last[hit]);
        if ((gap << 8) > allowance) begin
            res.verdict     = pkfd_pkg::V_DEVIATES;
            res.valid_ticks = book_ticks[hit];
        end else begin
            res.accepted   = 1'b1;
            res.verdict    = pkfd_pkg::V_UPDATED;
            book_last[hit] = px;
            if (book_ticks[hit] != '1) book_ticks[hit] = book_ticks[hit] + 1;
            res.valid_ticks = book_ticks[hit];
        end
        return res;
    endfunction

    // Drive requests from the pending queue; predict each one on acceptance
    always @(posedge clk) begin
        logic take;
        int   idle_pct;
        take = in_valid && !in_stall;
        if (take) begin
            expected_verdicts.push_back(screen_request(in_data));
            requests_sent++;
        end
        case (idle_mode)
            IDLE_SEND_LIGHT: idle_pct = 31;
            IDLE_SEND_HEAVY: idle_pct = 57;
            default:         idle_pct = 0;
        endcase
        if (!in_valid || take) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= pending_requests.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Check results against the oldest prediction and drive the output stall
    always @(posedge clk) begin
        pkfd_pkg::t_out want;
        int             idle_pct;
        if (out_valid && !out_stall) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, out_data);
                mismatches++;
            end else begin
                want = expected_verdicts.pop_front();
                verdict_seen[out_data.verdict]++;
                if (out_data.accepted !== want.accepted) begin
                    $display("%0t: accepted mismatch, expected %0b actual %0b",
                             $time, want.accepted, out_data.accepted);
                    mismatches++;
                end
                if (out_data.verdict !== want.verdict) begin
                    $display("%0t: verdict mismatch, expected %0d actual %0d",
                             $time, want.verdict, out_data.verdict);
                    mismatches++;
                end
                if (out_data.valid_ticks !== want.valid_ticks) begin
                    $display("%0t: valid_ticks mismatch, expected %0d actual %0d",
                             $time, want.valid_ticks, out_data.valid_ticks);
                    mismatches++;
                end
            end
        end
        case (idle_mode)
            IDLE_SEND_LIGHT: idle_pct = 57;
            IDLE_SEND_HEAVY: idle_pct = 31;
            default:         idle_pct = 0;
        endcase
        if (holdoff_left > 0) begin
            out_stall    <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_seen != holdoff_asks) begin
            holdoff_seen <= holdoff_asks;
            holdoff_left <= HOLDOFF_CYCLES;
            out_stall    <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("per_key_price_deviation_filter_unit test failed");
            $finish;
        end
    end

    task automatic offer(input logic [KEY_BITS-1:0] key, input logic [PRICE_BITS-1:0] px);
        pkfd_pkg::t_in req;
        req.symbol_key = key;
        req.price      = px;
        pending_requests.push_back(req);
    endtask

    // Hold until every queued request has been sent and answered
    task automatic settle();
        while (pending_requests.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [LIMIT_BITS-1:0] value);
        settle();
        @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_data   <= value;
        limit_copy = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [KEY_BITS-1:0]   pool_key  [POOL_KEYS];
        logic [PRICE_BITS-1:0] pool_base [POOL_KEYS];
        logic [KEY_BITS-1:0]   key;
        logic [PRICE_BITS-1:0] px;
        longint                tick_px;
        int                    pick;
        int                    slant;
        int                    roll;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, non-positive prices, limit boundaries at reset limit
        offer(KEY_ZERO, 48'd1);
        offer(KEY_ONES, PRICE_MAX);
        offer(KEY_BTC, '0);
        offer(KEY_BTC, PRICE_MIN);
        offer(KEY_BTC, '1);
        offer(KEY_BTC, 48'h0000_0001_0000);
        offer(KEY_ZERO, 48'd1);
        offer(KEY_EURUSD, 48'd256000);
        offer(KEY_EURUSD, 48'd384000);
        offer(KEY_EURUSD, 48'd576001);
        offer(KEY_EURUSD, 48'd192000);
        offer(KEY_ONES, PRICE_HALF);

        // Zero limit: only an unchanged price passes
        set_limit('0);
        offer(KEY_EURUSD, 48'd192000);
        offer(KEY_EURUSD, 48'd192001);
        offer(KEY_ZERO, 48'd1);

        // Widest limit, exact boundary on both sides
        set_limit('1);
        offer(KEY_EURUSD, 48'd384000);
        offer(KEY_EURUSD, 48'd383250);
        offer(KEY_EURUSD, 48'd1);
        offer(KEY_ONES, PRICE_MAX);

        // Build a pool of symbols with base prices across the whole range
        for (int i = 0; i < POOL_KEYS; i++) begin
            pool_key[i] = {$urandom, $urandom};
            case ($urandom_range(7))
                0:       pool_base[i] = 48'($urandom_range(1, 4095));
                1:       pool_base[i] = PRICE_MAX - 48'($urandom_range(0, 1 << 20));
                default: pool_base[i] = {1'b0, 47'({$urandom, $urandom})} >> $urandom_range(0, 28);
            endcase
            if (pool_base[i] == '0) pool_base[i] = 48'd1;
        end
        pool_key[0] = KEY_EURUSD;

        // Random batches; each starts from an idle block with a fresh limit
        for (int b = 0; b < BATCHES; b++) begin
            case (b % 4)
                0:       set_limit(LIMIT_RESET);
                1:       set_limit('0);
                2:       set_limit('1);
                default: set_limit(LIMIT_BITS'($urandom_range(1, 254)));
            endcase
            if (b < BATCHES / 3)
                idle_mode = IDLE_SEND_LIGHT;
            else if (b < 2 * BATCHES / 3)
                idle_mode = IDLE_SEND_HEAVY;
            else
                idle_mode = IDLE_NONE;

            for (int n = 0; n < BATCH_ITEMS; n++) begin
                roll = $urandom_range(99);
                if (roll < 8) begin
                    // non-positive noise on a known symbol
                    key = pool_key[$urandom_range(POOL_KEYS - 1)];
                    px  = ($urandom_range(3) == 0) ? '0 : {1'b1, 47'({$urandom, $urandom})};
                end else if (roll < 13) begin
                    // stray symbol with any positive price
                    key = {$urandom, $urandom};
                    px  = {1'b0, 47'({$urandom, $urandom})};
                    if (px == '0) px = 48'd1;
                end else begin
                    // pool symbol, price moved around its base
                    pick    = $urandom_range(POOL_KEYS - 1);
                    key     = pool_key[pick];
                    slant   = ($urandom_range(4) == 0) ? 0 : int'($urandom_range(400)) - 200;
                    tick_px = longint'(pool_base[pick])
                            + (longint'(pool_base[pick]) * slant) / 256;
                    if (tick_px > longint'(PRICE_MAX)) tick_px = longint'(PRICE_MAX);
                    if (tick_px < 1) tick_px = 1;
                    px = tick_px[PRICE_BITS-1:0];
                    if ($urandom_range(3) == 0) pool_base[pick] = px;
                end
                offer(key, px);
            end

            // Long output hold-off while the sender keeps offering
            if (b % 6 == 2) holdoff_asks = holdoff_asks + 1;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests over %0d symbols in book, limits 0/128/255/random.",
                 requests_sent, book_used);
        $display("Verdicts: %0d updated, %0d new, %0d full, %0d non-positive, %0d deviation.",
                 verdict_seen[pkfd_pkg::V_UPDATED], verdict_seen[pkfd_pkg::V_NEW],
                 verdict_seen[pkfd_pkg::V_FULL], verdict_seen[pkfd_pkg::V_NONPOS],
                 verdict_seen[pkfd_pkg::V_DEVIATES]);
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("per_key_price_deviation_filter_unit test passed");
        end else begin
            $display("per_key_price_deviation_filter_unit test failed");
        end
        $finish;
    end

endmodule
